// File: hdl/assert_macros.svh
// assertion macros shared by the alu rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPL(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error("%m: lbl");

`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error("%m: lbl");

`endif

// File: hdl/fpa_pkg.sv
// types and constants for the q24.8 alu
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package fpa_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ActW  = 3;

  typedef enum logic [ActW-1:0] {
    ACT_ADD = 3'd0,
    ACT_SUB = 3'd1,
    ACT_MUL = 3'd2,
    ACT_DIV = 3'd3,
    ACT_MIN = 3'd4,
    ACT_MAX = 3'd5
  } action_e;

  typedef struct packed {
    logic [DataW-1:0] result_value;
    logic             a_less;
    logic             a_equal;
    logic             a_greater;
    logic             overflow_flag;
    logic             divide_by_zero;
  } res_t;
endpackage
`default_nettype wire

// File: hdl/fpa_req_if.sv
// request and result channel interfaces
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none
interface fpa_req_if;
  logic                           valid;
  logic                           ready;
  logic [fpa_pkg::ActW-1:0]       action;
  logic signed [fpa_pkg::DataW-1:0] operand_a;
  logic signed [fpa_pkg::DataW-1:0] operand_b;
  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpa_res_if;
  logic                           valid;
  logic                           ready;
  logic signed [fpa_pkg::DataW-1:0] result_value;
  logic                           a_less;
  logic                           a_equal;
  logic                           a_greater;
  logic                           overflow_flag;
  logic                           divide_by_zero;
  modport source (output valid, result_value, a_less, a_equal, a_greater, overflow_flag,
                  divide_by_zero, input ready);
  modport sink (input valid, result_value, a_less, a_equal, a_greater, overflow_flag,
                divide_by_zero, output ready);
endinterface
`default_nettype wire

// File: hdl/fpa_div_cell.sv
// one restoring divide cell: one quotient bit per stage, carries the request along
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module fpa_div_cell #(
  parameter int unsigned NumW = 40,
  parameter int unsigned Idx  = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [NumW-1:0]   num_i,
  input  wire logic [32:0]       rem_i,
  input  wire logic [NumW-1:0]   quo_i,
  input  wire logic [31:0]       den_i,
  input  wire fpa_pkg::res_t     pass_i,
  input  wire logic              isdiv_i,
  input  wire logic              neg_i,
  output logic                   vld_o,
  output logic [NumW-1:0]        num_o,
  output logic [32:0]            rem_o,
  output logic [NumW-1:0]        quo_o,
  output logic [31:0]            den_o,
  output fpa_pkg::res_t          pass_o,
  output logic                   isdiv_o,
  output logic                   neg_o
);
  logic [33:0] shifted;
  logic [33:0] diff;
  logic        take;
  logic [32:0] rem_d;
  logic [NumW-1:0] quo_d;

  always_comb begin
    shifted = {rem_i, num_i[NumW-1-Idx]};
    diff    = shifted - {2'b00, den_i};
    take    = !diff[33];
    rem_d   = take ? diff[32:0] : shifted[32:0];
    quo_d   = quo_i;
    quo_d[NumW-1-Idx] = take;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o   <= num_i;
      rem_o   <= rem_d;
      quo_o   <= quo_d;
      den_o   <= den_i;
      pass_o  <= pass_i;
      isdiv_o <= isdiv_i;
      neg_o   <= neg_i;
    end
  end
endmodule
`default_nettype wire

// File: hdl/fpa_front.sv
// first stage: compare, add, subtract, min, max, 32x32 magnitude multiply, divide setup
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module fpa_front #(
  parameter int unsigned FracBits = 8,
  parameter int unsigned NumW = 32 + FracBits
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      en_i,
  input  wire logic                      vld_i,
  input  wire logic [fpa_pkg::ActW-1:0]  action_i,
  input  wire logic signed [31:0]        a_i,
  input  wire logic signed [31:0]        b_i,
  output logic                           vld_o,
  output fpa_pkg::res_t                  pass_o,
  output logic                           isdiv_o,
  output logic                           neg_o,
  output logic [NumW-1:0]                num_o,
  output logic [31:0]                    den_o
);
  logic [31:0] mag_a, mag_b;
  logic signed [32:0] sum, dif;
  logic [63:0] prod;
  logic [64:0] prod_r;
  logic [64-FracBits:0] q_mul;
  logic neg;
  fpa_pkg::res_t pass_d;

  function automatic logic [32:0] sat_s33(input logic signed [32:0] s, output logic ovf);
    logic [32:0] r;
    ovf = 1'b0;
    r = s;
    if (s > 33'sd2147483647) begin
      ovf = 1'b1; r = 33'h0_7FFF_FFFF;
    end else if (s < -33'sd2147483648) begin
      ovf = 1'b1; r = 33'h1_8000_0000;
    end
    return r;
  endfunction

  always_comb begin
    logic ovf;
    logic [32:0] t;
    mag_a = a_i[31] ? 32'(-a_i) : 32'(a_i);
    mag_b = b_i[31] ? 32'(-b_i) : 32'(b_i);
    neg   = a_i[31] ^ b_i[31];
    sum   = 33'(a_i) + 33'(b_i);
    dif   = 33'(a_i) - 33'(b_i);
    prod  = 64'(mag_a) * 64'(mag_b);
    prod_r = 65'(prod) + (65'd1 << (FracBits - 1));
    q_mul = prod_r[64:FracBits];
    pass_d = '0;
    pass_d.a_less    = a_i < b_i;
    pass_d.a_equal   = a_i == b_i;
    pass_d.a_greater = a_i > b_i;
    ovf = 1'b0;
    t = '0;
    unique case (action_i)
      fpa_pkg::ACT_ADD: begin
        t = sat_s33(sum, ovf);
        pass_d.result_value = t[31:0];
        pass_d.overflow_flag = ovf;
      end
      fpa_pkg::ACT_SUB: begin
        t = sat_s33(dif, ovf);
        pass_d.result_value = t[31:0];
        pass_d.overflow_flag = ovf;
      end
      fpa_pkg::ACT_MUL: begin
        if (neg && q_mul != '0) begin
          if (q_mul > (64-FracBits+1)'(33'h0_8000_0000)) begin
            pass_d.result_value = 32'h8000_0000; pass_d.overflow_flag = 1'b1;
          end else begin
            pass_d.result_value = 32'(-q_mul);
          end
        end else if (q_mul > (64-FracBits+1)'(33'h0_7FFF_FFFF)) begin
          pass_d.result_value = 32'h7FFF_FFFF; pass_d.overflow_flag = 1'b1;
        end else begin
          pass_d.result_value = q_mul[31:0];
        end
      end
      fpa_pkg::ACT_DIV: pass_d.divide_by_zero = (b_i == '0);
      fpa_pkg::ACT_MIN: pass_d.result_value = (a_i < b_i) ? a_i : b_i;
      fpa_pkg::ACT_MAX: pass_d.result_value = (a_i > b_i) ? a_i : b_i;
      default: pass_d.result_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pass_o  <= pass_d;
      isdiv_o <= (action_i == fpa_pkg::ACT_DIV) && (b_i != '0);
      neg_o   <= neg;
      num_o   <= {mag_a, FracBits'(0)};
      den_o   <= mag_b;
    end
  end
endmodule
`default_nettype wire

// File: hdl/fpa_back.sv
// last stage: divide rounding and saturation, output register
// depends on fpa_pkg
`timescale 1ns / 1ps
`default_nettype none
module fpa_back #(
  parameter int unsigned NumW = 40
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire fpa_pkg::res_t     pass_i,
  input  wire logic              isdiv_i,
  input  wire logic              neg_i,
  input  wire logic [NumW-1:0]   quo_i,
  input  wire logic [32:0]       rem_i,
  input  wire logic [31:0]       den_i,
  output logic                   vld_o,
  output fpa_pkg::res_t          res_o
);
  logic [NumW:0] q;
  logic          up;
  fpa_pkg::res_t res_d;

  always_comb begin
    up = {rem_i, 1'b0} >= {2'b00, den_i};
    q  = (NumW+1)'(quo_i) + (NumW+1)'(up);
    res_d = pass_i;
    if (isdiv_i) begin
      if (neg_i && q != '0) begin
        if (q > (NumW+1)'(33'h0_8000_0000)) begin
          res_d.result_value = 32'h8000_0000; res_d.overflow_flag = 1'b1;
        end else begin
          res_d.result_value = 32'(-q);
        end
      end else if (q > (NumW+1)'(33'h0_7FFF_FFFF)) begin
        res_d.result_value = 32'h7FFF_FFFF; res_d.overflow_flag = 1'b1;
      end else begin
        res_d.result_value = q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o <= 1'b0;
    end else if (en_i) begin
      vld_o <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end
endmodule
`default_nettype wire

// File: hdl/fixed_point_q24_8_alu.sv
// Signed Q24.8 fixed-point ALU: one request per cycle while the pipe is not stalled.
// Every request, not only divides, flows through the divider's chain of cells, one
// quotient bit per cell, so results stay in order; the whole pipe stalls while the
// output register holds an untaken result. Multiply and divide round to nearest with
// ties away from zero and saturate with overflow; divide by zero gives 0 and its flag.
// depends on fpa_pkg, fpa_req_if, fpa_div_cell, fpa_front, fpa_back
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module fixed_point_q24_8_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  fpa_req_if.sink   req_i,
  fpa_res_if.source res_o
);
  localparam int unsigned NumW = 32 + FRAC_BITS;

  logic en;
  logic vld [NumW+1];
  logic [NumW-1:0] num [NumW+1];
  logic [32:0] rem [NumW+1];
  logic [NumW-1:0] quo [NumW+1];
  logic [31:0] den [NumW+1];
  fpa_pkg::res_t pass [NumW+1];
  logic isdiv [NumW+1];
  logic neg [NumW+1];
  logic out_vld;
  fpa_pkg::res_t out_res;

  assign en = !out_vld || res_o.ready;
  assign req_i.ready = en;

  fpa_front #(.FracBits(FRAC_BITS), .NumW(NumW)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(req_i.valid), .action_i(req_i.action),
    .a_i(req_i.operand_a), .b_i(req_i.operand_b), .vld_o(vld[0]), .pass_o(pass[0]),
    .isdiv_o(isdiv[0]), .neg_o(neg[0]), .num_o(num[0]), .den_o(den[0])
  );
  assign rem[0] = '0;
  assign quo[0] = '0;

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    fpa_div_cell #(.NumW(NumW), .Idx(i)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .vld_i(vld[i]), .num_i(num[i]), .rem_i(rem[i]),
      .quo_i(quo[i]), .den_i(den[i]), .pass_i(pass[i]), .isdiv_i(isdiv[i]),
      .neg_i(neg[i]), .vld_o(vld[i+1]), .num_o(num[i+1]), .rem_o(rem[i+1]),
      .quo_o(quo[i+1]), .den_o(den[i+1]), .pass_o(pass[i+1]), .isdiv_o(isdiv[i+1]),
      .neg_o(neg[i+1])
    );
  end

  fpa_back #(.NumW(NumW)) u_back (
    .clk_i, .rst_ni, .en_i(en), .vld_i(vld[NumW]), .pass_i(pass[NumW]),
    .isdiv_i(isdiv[NumW]), .neg_i(neg[NumW]), .quo_i(quo[NumW]), .rem_i(rem[NumW]),
    .den_i(den[NumW]), .vld_o(out_vld), .res_o(out_res)
  );

  assign res_o.valid          = out_vld;
  assign res_o.result_value   = out_res.result_value;
  assign res_o.a_less         = out_res.a_less;
  assign res_o.a_equal        = out_res.a_equal;
  assign res_o.a_greater      = out_res.a_greater;
  assign res_o.overflow_flag  = out_res.overflow_flag;
  assign res_o.divide_by_zero = out_res.divide_by_zero;

  `ASSERT_IMPL(a_one_cmp, clk_i, rst_ni,
    !out_vld || $onehot({out_res.a_less, out_res.a_equal, out_res.a_greater}))
  `ASSERT_IMPL(a_flags_excl, clk_i, rst_ni,
    !out_vld || !(out_res.overflow_flag && out_res.divide_by_zero))
  `ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_vld && !res_o.ready,
    out_vld && $stable(out_res))
endmodule
`default_nettype wire
